@@ design/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by hcbp_code_table and huffman_code_bit_packer.
package hcbp_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_LEN_W   = 6;
	localparam int SYM_W         = 8;
	localparam int TABLE_DEPTH   = 256;
	localparam int REQ_W         = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_END    = 2'd2
	} req_kind_t;

	localparam logic [SYM_W-1:0] NEWLINE_BYTE = 8'd10;
	localparam logic [SYM_W-1:0] PERCENT_BYTE = 8'd37;

endpackage

@@ design/hcbp_code_table.sv @@
// Code table: 256 entries of code and length in a synchronous memory.
// Per-entry valid bits make never-written entries read as length zero.
// Depends on hcbp_pkg.
module hcbp_code_table #(
	parameter int WORD_BITS = hcbp_pkg::WORD_BITS_DEF,
	parameter int LEN_W     = $clog2(WORD_BITS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [hcbp_pkg::SYM_W-1:0]  wr_addr,
	input  logic [WORD_BITS-1:0]        wr_code,
	input  logic [LEN_W-1:0]            wr_len,
	input  logic                        rd_en,
	input  logic [hcbp_pkg::SYM_W-1:0]  rd_addr,
	output logic [WORD_BITS-1:0]        rd_code,
	output logic [LEN_W-1:0]            rd_len
);
	import hcbp_pkg::*;

	localparam int ENTRY_W = WORD_BITS + LEN_W;

	logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] entry_vld_q;
	logic [ENTRY_W-1:0]     rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_len, wr_code};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= entry_vld_q[rd_addr];
			end
		end
	end

	// An entry that was never loaded reads as an uncoded symbol.
	assign rd_code = rd_vld_q ? rd_data_q[WORD_BITS-1:0] : '0;
	assign rd_len  = rd_vld_q ? rd_data_q[ENTRY_W-1:WORD_BITS] : '0;

endmodule

@@ design/huffman_code_bit_packer.sv @@
// Huffman encoder back end: code table lookup and MSB-first bit packing.
// Depends on hcbp_pkg and hcbp_code_table.
//
// Channel | Direction | Handshake          | Word contents
// --------+-----------+--------------------+------------------------------------------
// in      | input     | in_valid/in_stall  | req_type, symbol, code_value, code_length
// out     | output    | out_valid/out_stall| packed_word, valid_bits, is_last
//
// One input word is taken every cycle while the input is not stalled. A load
// writes the code table at the edge it is accepted; an encode reads the table
// at that edge, and when the merge stage advances it merges the code into the
// accumulator and loads any result word into the output register together.
// Reset clears the table's valid bits at once; no clearing pass is needed.
// The input stalls only while the merge stage holds a result word and the
// output register is full and stalled.
module huffman_code_bit_packer #(
	parameter int WORD_BITS = hcbp_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [hcbp_pkg::REQ_W-1:0]       req_type,
	input  logic [hcbp_pkg::SYM_W-1:0]       symbol,
	input  logic [WORD_BITS-1:0]             code_value,
	input  logic [hcbp_pkg::FIELD_LEN_W-1:0] code_length,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [WORD_BITS-1:0]             packed_word,
	output logic [hcbp_pkg::FIELD_LEN_W-1:0] valid_bits,
	output logic                             is_last
);
	import hcbp_pkg::*;

	// Length of a stored code (0..WORD_BITS), pending count (< WORD_BITS),
	// and pending count plus one code (< 2*WORD_BITS).
	localparam int LEN_W = $clog2(WORD_BITS + 1);
	localparam int CNT_W = $clog2(WORD_BITS);
	localparam int TOT_W = $clog2(2 * WORD_BITS);

	req_kind_t               kind;
	logic                    accept;
	logic                    is_load;
	logic [LEN_W-1:0]        clamp_len;
	logic [WORD_BITS:0]      len_mask;
	logic [WORD_BITS-1:0]    wr_code;
	logic [SYM_W-1:0]        lookup_idx;
	logic                    enter_s1;

	logic                    s1_valid_s1;
	logic                    s1_end_s1;
	logic [WORD_BITS-1:0]    rd_code;
	logic [LEN_W-1:0]        rd_len;

	logic [WORD_BITS-1:0]    acc_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [TOT_W-1:0]        total;
	logic [TOT_W-1:0]        rest_full;
	logic [CNT_W-1:0]        rest;
	logic [2*WORD_BITS-1:0]  merged;
	logic [2*WORD_BITS-1:0]  shifted;
	logic [WORD_BITS-1:0]    rest_mask;
	logic                    word_full;
	logic                    needs_out;
	logic                    out_free;
	logic                    s1_adv;

	logic                    out_valid_q;
	logic [WORD_BITS-1:0]    packed_word_q;
	logic [FIELD_LEN_W-1:0]  valid_bits_q;
	logic                    is_last_q;

	// ---------------------------------------------------------------
	// Input side: table writes for loads, table reads for encodes.
	// ---------------------------------------------------------------
	assign kind     = req_kind_t'(req_type);
	assign in_stall = s1_valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_load  = 1'b0;
		enter_s1 = 1'b0;
		case (kind)
			REQ_LOAD: begin
				is_load = 1'b1;
			end
			REQ_ENCODE: begin
				enter_s1 = 1'b1;
			end
			REQ_END: begin
				enter_s1 = 1'b1;
			end
			default: begin
				// The unused request code is dropped without effect.
				is_load  = 1'b0;
				enter_s1 = 1'b0;
			end
		endcase
	end

	// Lengths above the word size are stored as the word size, and only
	// the low length bits of the code are kept.
	assign clamp_len = (code_length > FIELD_LEN_W'(WORD_BITS)) ?
		LEN_W'(WORD_BITS) : code_length[LEN_W-1:0];
	assign len_mask  = ((WORD_BITS + 1)'(1) << clamp_len) - (WORD_BITS + 1)'(1);
	assign wr_code   = code_value & len_mask[WORD_BITS-1:0];

	// A newline is always encoded with the entry of the percent sign.
	assign lookup_idx = (symbol == NEWLINE_BYTE) ? PERCENT_BYTE : symbol;

	hcbp_code_table #(
		.WORD_BITS (WORD_BITS),
		.LEN_W     (LEN_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_load),
		.wr_addr (symbol),
		.wr_code (wr_code),
		.wr_len  (clamp_len),
		.rd_en   (accept && enter_s1 && (kind == REQ_ENCODE)),
		.rd_addr (lookup_idx),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	// Because a table write lands at the edge its load is accepted and a
	// read is taken at a later edge, a load followed by an encode of the
	// same symbol always sees the new entry: no forwarding is required.

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_s1 <= accept && enter_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s1_end_s1 <= (kind == REQ_END);
		end
	end

	// ---------------------------------------------------------------
	// Merge stage: shift the code into the accumulator, split off a
	// full word when the fill reaches the word size, clear on a flush.
	// ---------------------------------------------------------------
	assign total     = TOT_W'(cnt_q) + TOT_W'(rd_len);
	assign merged    = ({{WORD_BITS{1'b0}}, acc_q} << rd_len) | {{WORD_BITS{1'b0}}, rd_code};
	assign word_full = (total >= TOT_W'(WORD_BITS));
	assign rest_full = total - TOT_W'(WORD_BITS);
	assign rest      = rest_full[CNT_W-1:0];
	assign shifted   = merged >> rest;
	assign rest_mask = (WORD_BITS'(1) << rest) - WORD_BITS'(1);

	// An uncoded byte leaves the count unchanged, so it can never fill a word.
	assign needs_out = s1_end_s1 || word_full;
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_adv    = !s1_valid_s1 || !needs_out || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (s1_valid_s1 && s1_adv) begin
			if (s1_end_s1) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (word_full) begin
				acc_q <= merged[WORD_BITS-1:0] & rest_mask;
				cnt_q <= rest;
			end else begin
				acc_q <= merged[WORD_BITS-1:0];
				cnt_q <= total[CNT_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_s1 && needs_out && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && needs_out && out_free) begin
			if (s1_end_s1) begin
				packed_word_q <= acc_q;
				valid_bits_q  <= FIELD_LEN_W'(cnt_q);
				is_last_q     <= 1'b1;
			end else begin
				packed_word_q <= shifted[WORD_BITS-1:0];
				valid_bits_q  <= FIELD_LEN_W'(WORD_BITS);
				is_last_q     <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_word = packed_word_q;
	assign valid_bits  = valid_bits_q;
	assign is_last     = is_last_q;

	// ---------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && s1_adv && s1_end_s1 |=> cnt_q == '0)
		else $error("accumulator count not cleared after flush");

	a_full_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> valid_bits == FIELD_LEN_W'(WORD_BITS))
		else $error("full word without full bit count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1 && needs_out && out_valid_q && out_stall)
		else $error("input stalled without a blocked result word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		TOT_W'(cnt_q) < TOT_W'(WORD_BITS))
		else $error("pending count reached the word size");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_bit_packer: table loads, MSB-first packing, flushes.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL; needs no files or arguments.

module tb;
	import hcbp_pkg::*;

	localparam int WB          = WORD_BITS_DEF;
	localparam int RANDOM_REQS = 900;
	localparam int PRELOADS    = 40;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 8;

	// Request code 3 is not defined by the package. The block must ignore it.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// One input word as the sender sees it. A word marked drain_first is held
	// back until the block has delivered every packed word it still owes.
	typedef struct {
		logic [REQ_W-1:0]       kind;
		logic [SYM_W-1:0]       sym;
		logic [WB-1:0]          code;
		logic [FIELD_LEN_W-1:0] len;
		bit                     drain_first;
	} request_t;

	typedef struct {
		logic [WB-1:0]          word;
		logic [FIELD_LEN_W-1:0] bits;
		logic                   last;
	} packed_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [REQ_W-1:0]       req_type = REQ_LOAD;
	logic [SYM_W-1:0]       symbol = '0;
	logic [WB-1:0]          code_value = '0;
	logic [FIELD_LEN_W-1:0] code_length = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [WB-1:0]          packed_word;
	logic [FIELD_LEN_W-1:0] valid_bits;
	logic                   is_last;

	huffman_code_bit_packer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.symbol      (symbol),
		.code_value  (code_value),
		.code_length (code_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_word (packed_word),
		.valid_bits  (valid_bits),
		.is_last     (is_last)
	);

	// Two ns period: one ns high, one ns low.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Requests still to be sent, and the packed words the block owes us.
	request_t pending_reqs[$];
	packed_t  owed_words[$];

	// Our own copy of the code table and the bit accumulator.
	logic [WB-1:0]          code_of[TABLE_DEPTH];
	logic [FIELD_LEN_W-1:0] len_of[TABLE_DEPTH];
	logic [WB-1:0]          acc_bits = '0;
	int                     acc_fill = 0;

	int n_planned = 0;
	int n_taken   = 0;
	int n_loads   = 0;
	int n_encodes = 0;
	int n_flushes = 0;
	int n_ignored = 0;
	int n_checked = 0;
	int n_errors  = 0;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			code_of[i] = '0;
			len_of[i]  = '0;
		end
	end

	// Applies one accepted request to the local table and accumulator and
	// queues the packed word it causes, if any. A load clamps the length to
	// the word width and keeps only the low code bits. A newline byte is
	// encoded with the entry of the percent sign. A full word leaves as soon
	// as the accumulator reaches the word width; a flush always sends the
	// partial word, even when it holds no bits.
	function automatic void pack_request(input request_t r);
		logic [SYM_W-1:0]       idx;
		logic [FIELD_LEN_W-1:0] n;
		logic [63:0]            merged;
		int                     total;
		int                     rest;
		packed_t                out;
		case (r.kind)
			REQ_LOAD: begin
				n = (r.len > WB) ? FIELD_LEN_W'(WB) : r.len;
				len_of[r.sym]  = n;
				code_of[r.sym] = WB'({32'b0, r.code} & ((64'd1 << n) - 64'd1));
				n_loads++;
			end
			REQ_ENCODE: begin
				idx = (r.sym == NEWLINE_BYTE) ? PERCENT_BYTE : r.sym;
				n   = len_of[idx];
				n_encodes++;
				if (n != 0) begin
					merged = ({32'b0, acc_bits} << n) | {32'b0, code_of[idx]};
					total  = acc_fill + int'(n);
					if (total >= WB) begin
						rest     = total - WB;
						out.word = WB'(merged >> rest);
						out.bits = FIELD_LEN_W'(WB);
						out.last = 1'b0;
						owed_words = {owed_words, out};
						acc_bits = WB'(merged & ((64'd1 << rest) - 64'd1));
						acc_fill = rest;
					end else begin
						acc_bits = WB'(merged);
						acc_fill = total;
					end
				end
			end
			REQ_END: begin
				out.word = acc_bits;
				out.bits = FIELD_LEN_W'(acc_fill);
				out.last = 1'b1;
				owed_words = {owed_words, out};
				acc_bits = '0;
				acc_fill = 0;
				n_flushes++;
			end
			default: begin
				n_ignored++;
			end
		endcase
	endfunction

	// Sender. Words go out in bursts of random length separated by random
	// gaps; about a third of the gaps are zero, so bursts also run back to
	// back. A word is only replaced once it has been taken, so a stalled
	// word stays put and valid is assigned at most once per edge.
	request_t cur_req;
	int       burst_left = 0;
	int       gap_left   = 0;
	logic     launch;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			req_type    <= REQ_LOAD;
			symbol      <= '0;
			code_value  <= '0;
			code_length <= '0;
			burst_left  = 0;
			gap_left    = 0;
		end else begin
			if (in_valid && !in_stall) begin
				pack_request(cur_req);
				n_taken++;
			end
			if (!in_valid || !in_stall) begin
				launch = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].drain_first && owed_words.size() != 0)) begin
					launch  = 1'b1;
					cur_req = pending_reqs.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				in_valid <= launch;
				if (launch) begin
					req_type    <= cur_req.kind;
					symbol      <= cur_req.sym;
					code_value  <= cur_req.code;
					code_length <= cur_req.len;
				end
			end
		end
	end

	// Receiver. It checks every word it takes against the oldest owed word,
	// and stalls on a pattern of its own: modes of no stall, light stall,
	// heavy stall and strict alternation, each lasting a random while.
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	packed_t     due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode = STALL_NONE;
			mode_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (owed_words.size() == 0) begin
					$display("%0t: packed word %h (%0d bits, last %0b) arrived with none owed",
						$time, packed_word, valid_bits, is_last);
					n_errors++;
				end else begin
					due = owed_words.pop_front();
					if (packed_word !== due.word) begin
						$display("%0t: packed_word expected %h, actual %h",
							$time, due.word, packed_word);
						n_errors++;
					end
					if (valid_bits !== due.bits) begin
						$display("%0t: valid_bits expected %0d, actual %0d",
							$time, due.bits, valid_bits);
						n_errors++;
					end
					if (is_last !== due.last) begin
						$display("%0t: is_last expected %b, actual %b",
							$time, due.last, is_last);
						n_errors++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	// Watchdog: too many cycles in a row with no word taken on either side
	// means the block has hung.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d requests sent of %0d",
				$time, IDLE_LIMIT, n_taken, n_planned);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void add_req(input logic [REQ_W-1:0] kind, input logic [SYM_W-1:0] sym,
			input logic [WB-1:0] code, input logic [FIELD_LEN_W-1:0] len, input bit drain_first);
		request_t r;
		r.kind        = kind;
		r.sym         = sym;
		r.code        = code;
		r.len         = len;
		r.drain_first = drain_first;
		pending_reqs = {pending_reqs, r};
		n_planned++;
	endfunction

	// Code lengths lean toward short codes, as a real code would, with some
	// long ones, exact full-word codes, no-code entries and oversized lengths.
	function automatic logic [FIELD_LEN_W-1:0] pick_len();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return FIELD_LEN_W'(WB);
		if (roll == 2)
			return FIELD_LEN_W'($urandom_range(WB + 1, 63));
		if (roll <= 5)
			return FIELD_LEN_W'($urandom_range(13, WB - 1));
		return FIELD_LEN_W'($urandom_range(1, 12));
	endfunction

	logic [SYM_W-1:0]       coded_syms[$];
	logic [SYM_W-1:0]       sym;
	logic [FIELD_LEN_W-1:0] len;
	int                     roll;

	initial begin
		// Directed part. A flush of an empty accumulator, an uncoded byte
		// and an undefined request type come first, on the reset table.
		add_req(REQ_END, 8'd0, '0, '0, 1'b0);
		add_req(REQ_ENCODE, 8'd0, '0, '0, 1'b0);
		add_req(REQ_UNUSED, 8'hFF, '1, '1, 1'b0);
		// Table extremes: a full-word code, a one-bit code with junk above
		// it, the percent entry, an entry at the newline index that must
		// never be used, an oversized length and an all-zero code.
		add_req(REQ_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
		add_req(REQ_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd1, 1'b0);
		add_req(REQ_LOAD, PERCENT_BYTE, 32'hFFFF_FFF5, 6'd3, 1'b0);
		add_req(REQ_LOAD, NEWLINE_BYTE, 32'h0000_03FF, 6'd10, 1'b0);
		add_req(REQ_LOAD, 8'd1, 32'hDEAD_BEEF, 6'd63, 1'b0);
		add_req(REQ_LOAD, 8'd2, 32'h0000_0000, 6'd7, 1'b0);
		// A full-word code on an empty accumulator leaves at once.
		add_req(REQ_ENCODE, 8'd255, '0, '0, 1'b0);
		add_req(REQ_ENCODE, NEWLINE_BYTE, '0, '0, 1'b0);
		add_req(REQ_ENCODE, PERCENT_BYTE, '0, '0, 1'b0);
		add_req(REQ_ENCODE, 8'd0, '0, '0, 1'b0);
		add_req(REQ_ENCODE, 8'd2, '0, '0, 1'b0);
		// A full-word code on a partly filled accumulator splits across words.
		add_req(REQ_ENCODE, 8'd1, '0, '0, 1'b0);
		add_req(REQ_END, 8'd0, '0, '0, 1'b0);
		// Two half-word codes fill a word exactly; the flush is then empty.
		add_req(REQ_LOAD, 8'd3, 32'h1234_A5A5, 6'd16, 1'b0);
		add_req(REQ_ENCODE, 8'd3, '0, '0, 1'b0);
		add_req(REQ_ENCODE, 8'd3, '0, '0, 1'b0);
		add_req(REQ_END, 8'd0, '0, '0, 1'b0);
		// Removing a code: the byte then adds nothing.
		add_req(REQ_LOAD, 8'd0, 32'h5555_5555, 6'd0, 1'b0);
		add_req(REQ_ENCODE, 8'd0, '0, '0, 1'b0);
		add_req(REQ_ENCODE, 8'd255, '0, '0, 1'b0);
		add_req(REQ_END, 8'd0, '0, '0, 1'b0);
		coded_syms = {coded_syms, 8'd1};
		coded_syms = {coded_syms, 8'd2};
		coded_syms = {coded_syms, 8'd3};
		coded_syms = {coded_syms, 8'd255};
		coded_syms = {coded_syms, PERCENT_BYTE};

		// Fill part of the table so that most encodes find a code.
		for (int i = 0; i < PRELOADS; i++) begin
			sym = 8'($urandom_range(0, 255));
			len = pick_len();
			add_req(REQ_LOAD, sym, $urandom, len, i == 0);
			if (len != 0)
				coded_syms = {coded_syms, sym};
		end

		// Random stream, mostly encodes of coded bytes, with table updates,
		// flushes, uncoded and newline bytes and undefined requests mixed in.
		// A few words wait until the block has caught up completely.
		for (int i = 0; i < RANDOM_REQS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				sym = ($urandom_range(0, 19) == 0) ? NEWLINE_BYTE : 8'($urandom_range(0, 255));
				len = pick_len();
				add_req(REQ_LOAD, sym, $urandom, len, i % 300 == 150);
				if (len != 0)
					coded_syms = {coded_syms, sym};
			end else if (roll < 16) begin
				add_req(REQ_END, 8'($urandom), $urandom, 6'($urandom), i % 300 == 150);
			end else if (roll < 19) begin
				add_req(REQ_UNUSED, 8'($urandom), $urandom, 6'($urandom), i % 300 == 150);
			end else begin
				roll = $urandom_range(0, 19);
				if (roll == 0)
					sym = NEWLINE_BYTE;
				else if (roll < 15)
					sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
				else
					sym = 8'($urandom_range(0, 255));
				add_req(REQ_ENCODE, sym, $urandom, 6'($urandom), i % 300 == 150);
			end
		end
		add_req(REQ_END, 8'd0, '0, '0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Every request taken, every owed word delivered, then a short tail
		// to catch any stray word the block might still put out.
		wait (n_taken == n_planned);
		wait (owed_words.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d loads, %0d encodes, %0d flushes, %0d undefined.",
			n_taken, n_loads, n_encodes, n_flushes, n_ignored);
		$display("Checked %0d packed words; %0d field mismatches.", n_checked, n_errors);
		if (n_errors == 0 && owed_words.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
